[hdl/chr_pkg.sv]
// Package with the constants, types and helper functions of the counter hash generator.
package chr_pkg;

    // Field widths and counts.
    localparam int WORD_W     = 32;
    localparam int WORD_COUNT = 6;
    localparam int HASH_W     = 64;
    localparam int HALF_W     = HASH_W / 2;
    localparam int MANT_W     = 53;
    localparam int IN_DATA_W  = WORD_COUNT * WORD_W;
    localparam int OUT_DATA_W = ((MANT_W + 7) / 8) * 8;

    // Register stages of one mixer, and of one fold round (combine stage plus mixer).
    localparam int MIX_STAGES   = 5;
    localparam int ROUND_STAGES = MIX_STAGES + 1;

    // Hash constants.
    localparam logic [HASH_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [HASH_W-1:0] MIX_M1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [HASH_W-1:0] MIX_M2 = 64'h94d0_49bb_1331_11eb;

    // Shift amounts of the mixer, of the mantissa and of the combine step.
    localparam int SH_MIX_A  = 30;
    localparam int SH_MIX_B  = 27;
    localparam int SH_MIX_C  = 31;
    localparam int SH_MANT   = HASH_W - MANT_W;
    localparam int SH_FOLD_L = 6;
    localparam int SH_FOLD_R = 2;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [WORD_COUNT-1:0][WORD_W-1:0] words_t;
    typedef logic [WORD_COUNT-1:0][HASH_W-1:0] mixw_t;

    // Partial products of a 64-bit multiply kept modulo 2^64.
    typedef struct packed {
        logic [HASH_W-1:0] ll;
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] hl;
    } mul_parts_t;

    // Three 32x32 products; the high-by-high product falls outside 64 bits.
    function automatic mul_parts_t mul_split(hash_t x, hash_t m);
        mul_parts_t p;
        p.ll = HASH_W'(x[HALF_W-1:0]) * HASH_W'(m[HALF_W-1:0]);
        p.lh = HALF_W'(x[HALF_W-1:0] * m[HASH_W-1:HALF_W]);
        p.hl = HALF_W'(x[HASH_W-1:HALF_W] * m[HALF_W-1:0]);
        return p;
    endfunction

    // Sum of the partial products, modulo 2^64.
    function automatic hash_t mul_join(mul_parts_t p);
        logic [HALF_W-1:0] cross_sum;
        cross_sum = p.lh + p.hl;
        return p.ll + {cross_sum, {HALF_W{1'b0}}};
    endfunction

endpackage

[hdl/counter_hash_uniform_rng.sv]
// Top level of the counter hash generator: input stage, mixers, fold rounds and output skid.
// Pipeline from an accepted input beat to m_tvalid: input register, 5-stage seed and
// word mixers, six 6-stage fold rounds, 5-stage final mixer, output register.
// Throughput: one beat per cycle; the pipeline stalls only when the skid register is full.
// Reset: rst_n clears all valid bits, including the skid and output valid flags, and the seed to zero.
// The seed is read by the first mixer stage, so it must be written with no beat in flight.
module counter_hash_uniform_rng
    import chr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  seed_wr_en,
    input  logic [HASH_W-1:0]     seed_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // step_word, batch_word, codebook_word, position_word, vocab_word, purpose_word
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mantissa, then zero padding
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int ROUNDS = WORD_COUNT;

    hash_t              seed_reg;
    logic               en;
    logic               in_valid_reg;
    words_t             words_reg;
    logic               rnd_valid [0:ROUNDS];
    hash_t              rnd_acc   [0:ROUNDS];
    mixw_t              rnd_mw    [0:ROUNDS-1];
    logic               fin_valid;
    hash_t              fin_data;
    logic [MANT_W-1:0]  pipe_mant;
    logic               out_valid_reg;
    logic [MANT_W-1:0]  out_mant_reg;
    logic               skid_valid_reg;
    logic [MANT_W-1:0]  skid_mant_reg;

    // The whole pipeline advances while the skid register is empty.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr_en)
        begin
            seed_reg <= seed_wr_data;
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            words_reg <= words_t'(s_tdata);
        end
    end

    // Seed mix starts the running value; the six words are mixed alongside it.
    chr_mix u_seed_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_data   (seed_reg),
        .out_valid (rnd_valid[0]),
        .out_data  (rnd_acc[0])
    );

    for (genvar w = 0; w < WORD_COUNT; w++)
    begin : g_word_mix
        chr_mix u_word_mix (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (in_valid_reg),
            .in_data   ({{(HASH_W-WORD_W){1'b0}}, words_reg[w]}),
            .out_valid (),
            .out_data  (rnd_mw[0][w])
        );
    end

    // Fold rounds, one per counter word, in order step to purpose.
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        if (r < ROUNDS - 1)
        begin : g_mid
            chr_round u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (rnd_valid[r]),
                .acc_in    (rnd_acc[r]),
                .mw_in     (rnd_mw[r]),
                .out_valid (rnd_valid[r+1]),
                .acc_out   (rnd_acc[r+1]),
                .mw_out    (rnd_mw[r+1])
            );
        end
        else
        begin : g_last
            chr_round u_round (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (rnd_valid[r]),
                .acc_in    (rnd_acc[r]),
                .mw_in     (rnd_mw[r]),
                .out_valid (rnd_valid[r+1]),
                .acc_out   (rnd_acc[r+1]),
                .mw_out    ()
            );
        end
    end

    // Final mix; the mantissa is its top bits.
    chr_mix u_final_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rnd_valid[ROUNDS]),
        .in_data   (rnd_acc[ROUNDS]),
        .out_valid (fin_valid),
        .out_data  (fin_data)
    );

    assign pipe_mant = fin_data[HASH_W-1:SH_MANT];

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= fin_valid;
        end
        else if (fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_mant_reg <= skid_mant_reg;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_mant_reg <= pipe_mant;
        end
        else if (fin_valid)
        begin
            skid_mant_reg <= pipe_mant;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-MANT_W){1'b0}}, out_mant_reg};

endmodule

[hdl/chr_mix.sv]
// Five-stage pipelined 64-bit finalizer: add, xor-shift, multiply, xor-shift, multiply, xor-shift.
module chr_mix
    import chr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  hash_t in_data,
    output logic  out_valid,
    output hash_t out_data
);

    logic [4:0] vld_reg;
    hash_t      x1_reg, x1_next;
    mul_parts_t p2_reg, p2_next;
    hash_t      x3_reg, x3_next;
    mul_parts_t p4_reg, p4_next;
    hash_t      res_reg, res_next;
    hash_t      v1, y3, r5;

    // Stage logic: each stage holds either one set of 32x32 products or an add step and an xor-shift.
    always_comb
    begin
        v1       = in_data + GOLDEN;
        x1_next  = v1 ^ (v1 >> SH_MIX_A);
        p2_next  = mul_split(x1_reg, MIX_M1);
        y3       = mul_join(p2_reg);
        x3_next  = y3 ^ (y3 >> SH_MIX_B);
        p4_next  = mul_split(x3_reg, MIX_M2);
        r5       = mul_join(p4_reg);
        res_next = r5 ^ (r5 >> SH_MIX_C);
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Data registers of the five stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x1_next;
            p2_reg  <= p2_next;
            x3_reg  <= x3_next;
            p4_reg  <= p4_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_data  = res_reg;

endmodule

[hdl/chr_round.sv]
// One fold round: the combine step in one stage, then a full mix of the combined value.
module chr_round
    import chr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  hash_t acc_in,
    input  mixw_t mw_in,
    output logic  out_valid,
    output hash_t acc_out,
    output mixw_t mw_out
);

    logic  pre_valid_reg;
    hash_t pre_reg, pre_next;
    mixw_t mw_dly_reg [0:ROUND_STAGES-1];

    // Combine the running value with the mixed word that this round consumes.
    always_comb
    begin
        pre_next = acc_in ^ (mw_in[0] + GOLDEN + (acc_in << SH_FOLD_L)
                             + (acc_in >> SH_FOLD_R));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    // The remaining mixed words shift down by one and follow the item.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg       <= pre_next;
            mw_dly_reg[0] <= mw_in >> HASH_W;
            for (int i = 1; i < ROUND_STAGES; i++)
            begin
                mw_dly_reg[i] <= mw_dly_reg[i-1];
            end
        end
    end

    chr_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid_reg),
        .in_data   (pre_reg),
        .out_valid (out_valid),
        .out_data  (acc_out)
    );

    assign mw_out = mw_dly_reg[ROUND_STAGES-1];

endmodule

[tb/testbench.sv]
// Self-checking testbench for the counter hash uniform random generator.
module testbench
    import chr_pkg::*;
();

    localparam int SETTLE_CYCLES = 100;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int IDLE_PCT      = 38;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  seed_wr_en = 1'b0;
    logic [HASH_W-1:0]     seed_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Counters waiting to be sent, and mantissas predicted for accepted counters.
    words_t              counter_q[$];
    logic [MANT_W-1:0]   mantissa_q[$];
    hash_t               seed_copy = '0;
    int                  idle_pct = IDLE_PCT;
    int                  error_count = 0;
    int                  cycle_count = 0;
    logic                in_fire = 1'b0;

    counter_hash_uniform_rng u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always #1 clk = ~clk;

    // The splitmix64 finalizer, all arithmetic modulo 2^64.
    function automatic hash_t splitmix_final(hash_t v);
        hash_t x;
        x = v + GOLDEN;
        x = (x ^ (x >> SH_MIX_A)) * MIX_M1;
        x = (x ^ (x >> SH_MIX_B)) * MIX_M2;
        return x ^ (x >> SH_MIX_C);
    endfunction

    // Expected mantissa for one six-word counter under a given seed.
    function automatic logic [MANT_W-1:0] predict_mantissa(hash_t seed, words_t words);
        hash_t acc;
        hash_t w;
        int    i;
        acc = splitmix_final(seed);
        for (i = 0; i < WORD_COUNT; i++)
        begin
            w = HASH_W'(words[i]);
            acc = splitmix_final(acc ^ (splitmix_final(w) + GOLDEN
                                        + (acc << SH_FOLD_L) + (acc >> SH_FOLD_R)));
        end
        acc = splitmix_final(acc);
        return MANT_W'(acc >> SH_MANT);
    endfunction

    // Counter words lean toward small indices and extremes, with full-range values mixed in.
    function automatic logic [WORD_W-1:0] rand_word();
        unique case ($urandom_range(0, 5))
            0: return WORD_W'($urandom_range(0, 15));
            1: return WORD_W'($urandom_range(0, 4095));
            2: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    // Appends one counter to the send queue.
    task automatic queue_counter(input words_t item);
        counter_q = {counter_q, item};
    endtask

    task automatic load_random(input int count);
        words_t item;
        int     i;
        int     j;
        for (i = 0; i < count; i++)
        begin
            for (j = 0; j < WORD_COUNT; j++)
                item[j] = rand_word();
            queue_counter(item);
        end
    endtask

    // Hold off until every counter is sent and every mantissa has come back, then settle.
    task automatic drain_and_settle();
        do
            @(posedge clk);
        while (counter_q.size() != 0 || mantissa_q.size() != 0 || s_tvalid);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Seed writes happen only with the pipeline empty.
    task automatic write_seed(input hash_t value);
        @(negedge clk);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(negedge clk);
        seed_wr_en <= 1'b0;
        seed_copy = value;
    endtask

    // Driver: presents the next counter beat once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (counter_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                s_tdata  <= counter_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Input side: predict the mantissa of every accepted counter beat.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            mantissa_q = {mantissa_q, predict_mantissa(seed_copy, words_t'(s_tdata))};
            in_fire <= 1'b1;
        end
        else
            in_fire <= 1'b0;
    end

    // Output side: compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        logic [MANT_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mantissa_q.size() == 0)
            begin
                $error("unexpected result beat: mantissa %h", m_tdata[MANT_W-1:0]);
                error_count++;
            end
            else
            begin
                want = mantissa_q.pop_front();
                if (m_tdata[MANT_W-1:0] !== want)
                begin
                    $error("mantissa mismatch: expected %h, actual %h",
                           want, m_tdata[MANT_W-1:0]);
                    error_count++;
                end
                if (m_tdata[OUT_DATA_W-1:MANT_W] !== '0)
                begin
                    $error("padding mismatch: expected %h, actual %h",
                           {(OUT_DATA_W-MANT_W){1'b0}}, m_tdata[OUT_DATA_W-1:MANT_W]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Sequence of phases; the first runs under the reset seed, each later one writes its seed first.
    initial
    begin
        words_t item;
        int     i;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed counters under the reset seed of zero.
        queue_counter('0);
        queue_counter('1);
        for (i = 0; i < WORD_COUNT; i++)
        begin
            item = '0;
            item[i] = '1;
            queue_counter(item);
            item = '0;
            item[i] = WORD_W'(1);
            queue_counter(item);
        end
        queue_counter({WORD_COUNT{32'haaaa_aaaa}});
        queue_counter({WORD_COUNT{32'h5555_5555}});
        queue_counter({32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        queue_counter({32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1});
        drain_and_settle();

        // A seed of all ones is an ordinary seed.
        write_seed('1);
        load_random(150);
        drain_and_settle();

        write_seed({$urandom, $urandom});
        load_random(200);
        drain_and_settle();

        write_seed('0);
        load_random(100);
        drain_and_settle();

        // A long stretch with both sides always ready.
        write_seed(HASH_W'(1));
        idle_pct = 0;
        load_random(200);
        drain_and_settle();
        idle_pct = IDLE_PCT;

        write_seed({$urandom, $urandom});
        load_random(200);
        drain_and_settle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hdl/chr_pkg.sv
hdl/chr_mix.sv
hdl/chr_round.sv
hdl/counter_hash_uniform_rng.sv
tb/testbench.sv
